// ===== rtl/core/fnvkp_pkg.sv =====
package fnvkp_pkg;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned VAL_W   = 64;
	localparam int unsigned HASH_W  = 32;
	localparam int unsigned DEST_W  = 12;
	localparam int unsigned CNT_W   = 13;
	localparam int unsigned BYTES   = KEY_W / 8;
	// remainder bits folded in per modulo stage
	localparam int unsigned MOD_BITS   = 4;
	localparam int unsigned MOD_STAGES = HASH_W / MOD_BITS;

	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [CNT_W-1:0]  CNT_MAX   = 13'd4096;
	localparam logic [CNT_W-1:0]  CNT_RESET = 13'd1;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [DEST_W-1:0] rem;
	} pipe_t;

	function automatic logic [HASH_W-1:0] fnv_round(
		input logic [HASH_W-1:0] h,
		input logic [7:0]        b
	);
		logic [HASH_W-1:0] x;
		x = h ^ {24'd0, b};
		return HASH_W'(x * FNV_PRIME);
	endfunction

	// one restoring step: shift in a hash bit, subtract the count if it fits
	function automatic logic [DEST_W-1:0] rem_step(
		input logic [DEST_W-1:0] r,
		input logic              b,
		input logic [CNT_W-1:0]  n
	);
		logic [CNT_W-1:0] t;
		t = {r, b};
		if (t >= n) begin
			t = t - n;
		end
		return DEST_W'(t);
	endfunction

endpackage

// ===== rtl/core/fnvkp_hash_stage.sv =====
module fnvkp_hash_stage
	import fnvkp_pkg::*;
#(
	parameter int unsigned BYTE_IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output pipe_t out_data
);

	logic  vld_s1;
	pipe_t data_s1;
	logic [HASH_W-1:0] h_in;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	// first round starts from the offset basis
	assign h_in = (BYTE_IDX == 0) ? FNV_BASIS : in_data.hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.key   <= in_data.key;
			data_s1.value <= in_data.value;
			data_s1.hash  <= fnv_round(h_in, in_data.key[8*BYTE_IDX +: 8]);
			data_s1.rem   <= '0;
		end
	end

endmodule

// ===== rtl/core/fnvkp_mod_stage.sv =====
module fnvkp_mod_stage
	import fnvkp_pkg::*;
#(
	parameter int unsigned STAGE_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] divisor,
	input  logic             in_valid,
	output logic             in_ready,
	input  pipe_t            in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pipe_t            out_data
);

	localparam int unsigned TOP_BIT = HASH_W - 1 - STAGE_IDX * MOD_BITS;

	logic  vld_s1;
	pipe_t data_s1;
	logic [DEST_W-1:0] rem_nxt;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	// hash bits taken msb first
	always_comb begin
		rem_nxt = in_data.rem;
		for (int i = 0; i < MOD_BITS; i++) begin
			rem_nxt = rem_step(rem_nxt, in_data.hash[TOP_BIT - i], divisor);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.key   <= in_data.key;
			data_s1.value <= in_data.value;
			data_s1.hash  <= in_data.hash;
			data_s1.rem   <= rem_nxt;
		end
	end

endmodule

// ===== rtl/core/fnv1a_key_partitioner.sv =====
// Hash partitioner: each input transfer carries one tuple (key, value); the
// block computes 32-bit FNV-1a over the eight key bytes, least significant byte
// first, and sends out the destination partition (hash modulo partition_count),
// the hash and the unchanged tuple, one result per tuple, in order. The
// pipeline is 16 register stages deep: eight hash rounds (one byte each, one
// multiply by the FNV prime per stage) followed by eight remainder stages
// (four restoring steps each); a new tuple can enter every cycle while the
// output is not stalled. Each stage holds its item until the next one frees
// up, so stalls at the output fill the pipeline before the input backs off.
// partition_count is taken through cfg_we/cfg_wdata; zero counts
// as 1 and anything above 4096 as 4096. Change it only while the pipeline is
// empty, as the remainder stages read it live.
module fnv1a_key_partitioner
	import fnvkp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,     // partition_count
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [127:0]     s_axis_tdata,  // tuple_key[63:0], tuple_value[127:64]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// dest_partition[11:0], key_hash[43:12], out_key[107:44], out_value[171:108],
	// zero pad[175:172]
	output logic [175:0]     m_axis_tdata
);

	localparam int unsigned NSTG = BYTES + MOD_STAGES;

	logic [CNT_W-1:0] cnt_q;

	logic  vld [NSTG+1];
	logic  rdy [NSTG+1];
	pipe_t pl  [NSTG+1];

	// effective count kept clamped to 1..4096
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cnt_q <= CNT_RESET;
			end else if (cfg_wdata > CNT_MAX) begin
				cnt_q <= CNT_MAX;
			end else begin
				cnt_q <= cfg_wdata;
			end
		end
	end

	assign vld[0]         = s_axis_tvalid;
	assign s_axis_tready  = rdy[0];
	assign pl[0].key      = s_axis_tdata[63:0];
	assign pl[0].value    = s_axis_tdata[127:64];
	assign pl[0].hash     = FNV_BASIS;
	assign pl[0].rem      = '0;

	for (genvar g = 0; g < BYTES; g++) begin : g_hash
		fnvkp_hash_stage #(
			.BYTE_IDX(g)
		) u_hash (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[g]),
			.in_ready (rdy[g]),
			.in_data  (pl[g]),
			.out_valid(vld[g+1]),
			.out_ready(rdy[g+1]),
			.out_data (pl[g+1])
		);
	end

	for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
		fnvkp_mod_stage #(
			.STAGE_IDX(g)
		) u_mod (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (cnt_q),
			.in_valid (vld[BYTES+g]),
			.in_ready (rdy[BYTES+g]),
			.in_data  (pl[BYTES+g]),
			.out_valid(vld[BYTES+g+1]),
			.out_ready(rdy[BYTES+g+1]),
			.out_data (pl[BYTES+g+1])
		);
	end

	// last stage register is the output register
	assign rdy[NSTG]     = m_axis_tready;
	assign m_axis_tvalid = vld[NSTG];
	assign m_axis_tdata  = {4'd0, pl[NSTG].value, pl[NSTG].key, pl[NSTG].hash,
		pl[NSTG].rem};

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_MAX)
		else $error("partition count out of range");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld[1])
		else $error("accepted transfer lost at first stage");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !cfg_we && $stable(cnt_q) && $past(!cfg_we)
		|-> {1'b0, m_axis_tdata[11:0]} < cnt_q || $past(m_axis_tvalid))
		else $error("destination not below partition count");
`endif

endmodule
